@@ rtl/sfcu_pkg.sv @@
package sfcu_pkg;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned FuncW    = 2;
  localparam int unsigned MaskW    = 5;
  localparam int unsigned CondW    = 4;
  localparam int unsigned CountW   = 3;
  localparam int unsigned PrioW    = 3;

  localparam logic [PrioW-1:0] TopPrio = 3'd7;

  // Bit positions inside the flag mask.
  localparam int unsigned MaskCarry = 0;
  localparam int unsigned MaskZero  = 1;
  localparam int unsigned MaskNeg   = 2;
  localparam int unsigned MaskSleep = 3;
  localparam int unsigned MaskOvf   = 4;

  typedef enum logic [FuncW-1:0] {
    FUNC_SET_FLAGS = 2'd0,
    FUNC_CLR_FLAGS = 2'd1,
    FUNC_COND_EXEC = 2'd2,
    FUNC_SET_PRIO  = 2'd3
  } func_t;

  typedef enum logic [CondW-1:0] {
    COND_EQ = 4'd0,
    COND_NE = 4'd1,
    COND_CS = 4'd2,
    COND_CC = 4'd3,
    COND_MI = 4'd4,
    COND_PL = 4'd5,
    COND_VS = 4'd6,
    COND_VC = 4'd7,
    COND_HI = 4'd8,
    COND_LS = 4'd9,
    COND_GE = 4'd10,
    COND_LT = 4'd11,
    COND_GT = 4'd12,
    COND_LE = 4'd13,
    COND_TR = 4'd14,
    COND_FL = 4'd15
  } cond_t;

  typedef struct packed {
    logic [PrioW-1:0]  req_prio;
    logic [CountW-1:0] else_len;
    logic [CountW-1:0] then_len;
    logic [CondW-1:0]  cond_code;
    logic [MaskW-1:0]  flag_mask;
  } in_item_t;

  typedef struct packed {
    logic              priority_fault;
    logic [CountW-1:0] else_count;
    logic [CountW-1:0] then_count;
    logic              cex_armed;
    logic              cond_result;
    logic [PrioW-1:0]  priority_out;
    logic              sleep_out;
    logic              overflow_out;
    logic              negative_out;
    logic              zero_out;
    logic              carry_out;
  } out_item_t;

endpackage

@@ rtl/status_flags_and_condition_unit.sv @@
// Processor status word and condition unit. Each transfer on the input stream
// is one status instruction (set flags, clear flags, conditional execute, set
// priority); each produces exactly one transfer on the output stream showing
// the whole status state after the instruction plus a priority fault bit.
// An instruction is captured in an input register, evaluated against the
// status registers by a few gates, and written to the output register, and
// one instruction is accepted every cycle while the output side keeps taking
// results. The output register is the only point of back-pressure. After
// reset the flags are clear, the priority is 7 and conditional execution is
// disarmed.
module status_flags_and_condition_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [4:0] flag_mask, [8:5] cond_code, [11:9] then_len, [14:12] else_len,
  // [17:15] req_prio, [23:18] zero
  input  logic [sfcu_pkg::InDataW-1:0]   in_tdata,
  // [1:0] func
  input  logic [sfcu_pkg::FuncW-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [0] carry_out, [1] zero_out, [2] negative_out, [3] overflow_out,
  // [4] sleep_out, [7:5] priority_out, [8] cond_result, [9] cex_armed,
  // [12:10] then_count, [15:13] else_count, [16] priority_fault, [23:17] zero
  output logic [sfcu_pkg::OutDataW-1:0]  out_tdata
);
  import sfcu_pkg::*;

  localparam int unsigned ItemW = $bits(in_item_t);
  localparam int unsigned ResW  = $bits(out_item_t);

  // Input register.
  logic      in_vld_r;
  in_item_t  in_item_r;
  func_t     in_func_r;

  // Status state.
  logic              carry_r, zero_r, neg_r, ovf_r, sleep_r;
  logic [PrioW-1:0]  prio_r;
  logic              cond_r, cex_r;
  logic [CountW-1:0] then_r, else_r;

  logic              carry_nxt, zero_nxt, neg_nxt, ovf_nxt, sleep_nxt;
  logic [PrioW-1:0]  prio_nxt;
  logic              cond_nxt, cex_nxt;
  logic [CountW-1:0] then_nxt, else_nxt;
  logic              fault_nxt;
  logic              cond_eval;

  // Output register.
  logic      out_vld_r;
  out_item_t out_item_r;

  logic out_free;
  logic advance;

  assign out_free  = !out_vld_r || out_tready;
  assign advance   = in_vld_r && out_free;
  assign in_tready = !in_vld_r || out_free;

  always_comb begin
    case (cond_t'(in_item_r.cond_code))
      COND_EQ: cond_eval = zero_r;
      COND_NE: cond_eval = !zero_r;
      COND_CS: cond_eval = carry_r;
      COND_CC: cond_eval = !carry_r;
      COND_MI: cond_eval = neg_r;
      COND_PL: cond_eval = !neg_r;
      COND_VS: cond_eval = ovf_r;
      COND_VC: cond_eval = !ovf_r;
      COND_HI: cond_eval = carry_r && !zero_r;
      COND_LS: cond_eval = !carry_r || zero_r;
      COND_GE: cond_eval = !(neg_r ^ ovf_r);
      COND_LT: cond_eval = neg_r ^ ovf_r;
      COND_GT: cond_eval = !zero_r && !(neg_r ^ ovf_r);
      COND_LE: cond_eval = zero_r || (neg_r ^ ovf_r);
      COND_TR: cond_eval = 1'b1;
      default: cond_eval = 1'b0;
    endcase
  end

  always_comb begin
    carry_nxt = carry_r;
    zero_nxt  = zero_r;
    neg_nxt   = neg_r;
    ovf_nxt   = ovf_r;
    sleep_nxt = sleep_r;
    prio_nxt  = prio_r;
    cond_nxt  = cond_r;
    cex_nxt   = cex_r;
    then_nxt  = then_r;
    else_nxt  = else_r;
    fault_nxt = 1'b0;
    case (in_func_r)
      FUNC_SET_FLAGS: begin
        carry_nxt = carry_r | in_item_r.flag_mask[MaskCarry];
        zero_nxt  = zero_r  | in_item_r.flag_mask[MaskZero];
        neg_nxt   = neg_r   | in_item_r.flag_mask[MaskNeg];
        ovf_nxt   = ovf_r   | in_item_r.flag_mask[MaskOvf];
        // At the top priority the sleep flag is forced clear instead.
        if (prio_r == TopPrio) begin
          sleep_nxt = 1'b0;
        end else begin
          sleep_nxt = sleep_r | in_item_r.flag_mask[MaskSleep];
        end
      end
      FUNC_CLR_FLAGS: begin
        carry_nxt = carry_r & ~in_item_r.flag_mask[MaskCarry];
        zero_nxt  = zero_r  & ~in_item_r.flag_mask[MaskZero];
        neg_nxt   = neg_r   & ~in_item_r.flag_mask[MaskNeg];
        ovf_nxt   = ovf_r   & ~in_item_r.flag_mask[MaskOvf];
        sleep_nxt = sleep_r & ~in_item_r.flag_mask[MaskSleep];
      end
      FUNC_COND_EXEC: begin
        cond_nxt = cond_eval;
        cex_nxt  = 1'b1;
        then_nxt = in_item_r.then_len;
        else_nxt = in_item_r.else_len;
      end
      FUNC_SET_PRIO: begin
        if (in_item_r.req_prio < prio_r) begin
          prio_nxt = in_item_r.req_prio;
        end else begin
          fault_nxt = 1'b1;
        end
      end
      default: begin
        fault_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= in_item_t'(in_tdata[ItemW-1:0]);
      in_func_r <= func_t'(in_tuser);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= 1'b0;
      zero_r  <= 1'b0;
      neg_r   <= 1'b0;
      ovf_r   <= 1'b0;
      sleep_r <= 1'b0;
      prio_r  <= TopPrio;
      cond_r  <= 1'b0;
      cex_r   <= 1'b0;
      then_r  <= '0;
      else_r  <= '0;
    end else if (advance) begin
      carry_r <= carry_nxt;
      zero_r  <= zero_nxt;
      neg_r   <= neg_nxt;
      ovf_r   <= ovf_nxt;
      sleep_r <= sleep_nxt;
      prio_r  <= prio_nxt;
      cond_r  <= cond_nxt;
      cex_r   <= cex_nxt;
      then_r  <= then_nxt;
      else_r  <= else_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r.carry_out      <= carry_nxt;
      out_item_r.zero_out       <= zero_nxt;
      out_item_r.negative_out   <= neg_nxt;
      out_item_r.overflow_out   <= ovf_nxt;
      out_item_r.sleep_out      <= sleep_nxt;
      out_item_r.priority_out   <= prio_nxt;
      out_item_r.cond_result    <= cond_nxt;
      out_item_r.cex_armed      <= cex_nxt;
      out_item_r.then_count     <= then_nxt;
      out_item_r.else_count     <= else_nxt;
      out_item_r.priority_fault <= fault_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OutDataW-ResW){1'b0}}, out_item_r};

endmodule
